// ===== rtl/core/nau_pkg.sv =====
`default_nettype none

package nau_pkg;

   // Data format and table geometry.
   localparam int DATA_WIDTH     = 16;
   localparam int FRAC_BITS      = 10;
   localparam int TABLE_SEGMENTS = 64;

   // The sigmoid table covers magnitudes [0, ROM_SPAN) with Q2.30 entries.
   localparam int ROM_SPAN  = 8;
   localparam int ROM_W     = 32;
   localparam int Q_BITS    = 30;
   localparam int SLOPE_W   = 16;
   localparam int KIND_W    = 3;
   localparam int LATENCY   = 6;

   // Derived widths. The magnitude carries two extra bits because tanh looks
   // up twice the magnitude of the most negative input.
   localparam int MAG_W     = DATA_WIDTH + 2;
   localparam int IDX_W     = $clog2(TABLE_SEGMENTS + 1);
   localparam int SEG_SHIFT = FRAC_BITS + $clog2(ROM_SPAN);
   localparam int NUM_W     = (MAG_W + IDX_W > SEG_SHIFT) ? MAG_W + IDX_W : SEG_SHIFT + 1;
   localparam int ST_W      = FRAC_BITS + 1;
   localparam int RES_W     = (DATA_WIDTH > FRAC_BITS + 2) ? DATA_WIDTH : FRAC_BITS + 2;
   localparam int LEAK_W    = DATA_WIDTH + SLOPE_W + 1;

   localparam logic [ST_W-1:0]  ONE_FRAC = ST_W'(1) << FRAC_BITS;
   localparam logic [ROM_W-1:0] Q_ONE    = ROM_W'(1) << Q_BITS;
   localparam logic [ROM_W-1:0] Q_HALF   = ROM_W'(1) << (Q_BITS - 1);
   localparam logic [ROM_W-1:0] Q_ROUND  = ROM_W'(1) << (Q_BITS - 1 - FRAC_BITS);
   localparam logic [63:0]      Q_ONE64  = 64'd1 << Q_BITS;

   // Configuration port.
   localparam int PADDR_W   = 3;
   localparam int CSR_IDX_W = PADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_KIND  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE = CSR_IDX_W'(1);
   localparam logic [SLOPE_W-1:0]   SLOPE_RESET = SLOPE_W'(655);

   typedef enum logic [KIND_W-1:0] {
      KIND_LINEAR  = 3'd0,
      KIND_SIGMOID = 3'd1,
      KIND_RELU    = 3'd2,
      KIND_TANH    = 3'd3,
      KIND_LEAKY   = 3'd4
   } kind_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SLOPE_W-1:0] slope;
   } cfg_type;

   typedef struct packed {
      logic deriv;
      logic neg;
      logic pos;
   } ctl_type;

   typedef logic [ROM_W-1:0] rom_type [0:TABLE_SEGMENTS];

   // Restoring division, used only while the table is built at elaboration.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], num[i]};
         if (r >= {1'b0, den}) begin
            r = r - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Sigmoid samples at k*ROM_SPAN/TABLE_SEGMENTS, built from a Taylor series of exp(-h).
   function automatic rom_type build_rom();
      rom_type            rom;
      logic signed [63:0] sum;
      logic [63:0]        term;
      logic [63:0]        d;
      logic [63:0]        step;
      logic [63:0]        e;
      logic [63:0]        den;
      sum  = signed'(Q_ONE64);
      term = Q_ONE64;
      for (int n = 1; n <= 20; n++) begin
         d    = 64'(TABLE_SEGMENTS) * 64'(n);
         term = udiv64(term * 64'(ROM_SPAN) + (d >> 1), d);
         if ((n & 1) == 1) sum = sum - signed'(term);
         else sum = sum + signed'(term);
      end
      step = sum[63] ? 64'd0 : unsigned'(sum);
      e    = Q_ONE64;
      for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
         den    = Q_ONE64 + e;
         rom[k] = ROM_W'(udiv64((64'd1 << 60) + (den >> 1), den));
         e      = (e * step + (64'd1 << 29)) >> 30;
      end
      return rom;
   endfunction

   localparam rom_type SIG_ROM = build_rom();

   // Leaky slope moved from Q0.16 to the data format, rounded.
   function automatic logic [ST_W-1:0] slope_frac(input logic [SLOPE_W-1:0] slope);
      logic [SLOPE_W:0] biased;
      biased = '0;
      if (FRAC_BITS >= SLOPE_W) begin
         return ST_W'(slope) << (FRAC_BITS - SLOPE_W);
      end else begin
         biased = {1'b0, slope} + (SLOPE_W + 1)'(1 << (SLOPE_W - 1 - FRAC_BITS));
         return ST_W'(biased >> (SLOPE_W - FRAC_BITS));
      end
   endfunction

   function automatic logic [DATA_WIDTH-1:0] saturate(input logic [RES_W-1:0] v);
      logic [RES_W-DATA_WIDTH:0] top_bits;
      top_bits = v[RES_W-1:DATA_WIDTH-1];
      if ((&top_bits) || !(|top_bits)) return v[DATA_WIDTH-1:0];
      else if (v[RES_W-1]) return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      else return {1'b0, {(DATA_WIDTH-1){1'b1}}};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/neural_activation_unit.sv =====
`default_nettype none

// Channel    | Ports                                                | Handshake
// -----------+------------------------------------------------------+----------------------------
// request    | start, busy, req_action, req_value_in                | taken when start && !busy
// result     | rsp_strobe, rsp_value_out                            | one-cycle strobe, no stall
// config     | psel, penable, pwrite, paddr, pwdata, prdata, pready | APB access phase, ready high
//
// The unit takes one request every clock cycle outside reset and returns its
// result after a registered path through the table read, the interpolation
// multiply, the rounded add, the Q2.30 to Q5.10 conversion, the derivative
// multiply and the final select and saturation, one register each.
// Reset is synchronous and active high; it clears the valid pipeline and
// restores the registers (relu, leak slope 655). busy is high only during reset.
// The receiver cannot stall, so the pipeline never holds and never drops data.
module neural_activation_unit import nau_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_action,
   input  logic signed [DATA_WIDTH-1:0] req_value_in,
   output logic                         rsp_strobe,
   output logic signed [DATA_WIDTH-1:0] rsp_value_out,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [PADDR_W-1:0]           paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   cfg_type cfg;

   nau_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // A request is only refused while reset holds the pipeline clear.
   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // Valid bits, one per stage, travel beside the data.
   logic [LATENCY-1:0] vld_ff, vld_in;
   assign vld_in = {vld_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: magnitude for the table, leaky product, control flags.
   // Tanh uses the sigmoid table at twice the magnitude.
   // ---------------------------------------------------------------------
   logic [MAG_W-1:0]          x_ext;
   logic [MAG_W-1:0]          mag_abs;
   logic [MAG_W-1:0]          mag_sel;
   logic signed [LEAK_W-1:0]  lp1_in, lp1_ff;
   logic signed [DATA_WIDTH-1:0] x1_ff;
   ctl_type                   ctl1_in, ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff;
   logic [ROM_W-1:0]          p_tab;

   always_comb begin
      x_ext         = MAG_W'(req_value_in);
      ctl1_in.neg   = req_value_in[DATA_WIDTH-1];
      ctl1_in.pos   = !req_value_in[DATA_WIDTH-1] && (|req_value_in);
      ctl1_in.deriv = req_action;
      mag_abs       = ctl1_in.neg ? MAG_W'(0) - x_ext : x_ext;
      mag_sel       = (cfg.kind == KIND_TANH) ? (mag_abs << 1) : mag_abs;
      lp1_in        = LEAK_W'(req_value_in) * LEAK_W'(signed'({1'b0, cfg.slope}));
   end

   nau_interp u_interp (
      .clock  (clock),
      .mag_in (mag_sel),
      .p_out  (p_tab)
   );

   // ---------------------------------------------------------------------
   // Stage 2: the functions that need no table (linear, relu, leaky relu).
   // Codes outside the list behave as relu.
   // ---------------------------------------------------------------------
   logic signed [RES_W-1:0]  one_r;
   logic signed [RES_W-1:0]  x_r;
   logic signed [RES_W-1:0]  slope_r;
   logic signed [RES_W-1:0]  leak_r;
   logic signed [LEAK_W-1:0] leak_sum;
   logic signed [RES_W-1:0]  dir2_in, dir2_ff, dir3_ff, dir4_ff, dir5_ff;

   always_comb begin
      one_r    = signed'(RES_W'(ONE_FRAC));
      x_r      = RES_W'(x1_ff);
      slope_r  = signed'(RES_W'(slope_frac(cfg.slope)));
      // Round half up, then floor: an arithmetic shift floors.
      leak_sum = lp1_ff + LEAK_W'(32'sd32768);
      leak_r   = RES_W'(signed'(leak_sum[LEAK_W-1:SLOPE_W]));
      unique case (cfg.kind)
         KIND_LINEAR: dir2_in = ctl1_ff.deriv ? one_r : x_r;
         KIND_LEAKY: begin
            if (ctl1_ff.deriv) dir2_in = ctl1_ff.pos ? one_r : slope_r;
            else dir2_in = ctl1_ff.pos ? x_r : leak_r;
         end
         default: begin
            if (ctl1_ff.deriv) dir2_in = ctl1_ff.pos ? one_r : '0;
            else dir2_in = ctl1_ff.pos ? x_r : '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Stage 4: table result to the data format. The sigmoid mirrors for
   // negative inputs and is clamped one LSB inside (0, 1). Tanh is
   // 2*sigmoid(2|x|) - 1 on the magnitude.
   // ---------------------------------------------------------------------
   logic [ROM_W-1:0] ps;
   logic [ROM_W-1:0] tq;
   logic [ROM_W-1:0] s_sum;
   logic [ROM_W-1:0] t_sum;
   logic [ST_W-1:0]  s_raw;
   logic [ST_W-1:0]  s_clamp;
   logic [ST_W-1:0]  st4_in, st4_ff, st5_ff;

   always_comb begin
      ps      = ctl3_ff.neg ? Q_ONE - p_tab : p_tab;
      s_sum   = ps + Q_ROUND;
      s_raw   = ST_W'(s_sum >> (Q_BITS - FRAC_BITS));
      if (s_raw < ST_W'(1)) s_clamp = ST_W'(1);
      else if (s_raw > ONE_FRAC - ST_W'(1)) s_clamp = ONE_FRAC - ST_W'(1);
      else s_clamp = s_raw;
      tq      = (p_tab >= Q_HALF) ? (p_tab << 1) - Q_ONE : '0;
      t_sum   = tq + Q_ROUND;
      st4_in  = (cfg.kind == KIND_TANH) ? ST_W'(t_sum >> (Q_BITS - FRAC_BITS)) : s_clamp;
   end

   // ---------------------------------------------------------------------
   // Stage 5: derivative product, s*(1-s) for sigmoid, t*t for tanh.
   // ---------------------------------------------------------------------
   logic [ST_W-1:0]   mul_b;
   logic [2*ST_W-1:0] m5_in, m5_ff;

   always_comb begin
      mul_b = (cfg.kind == KIND_SIGMOID) ? ONE_FRAC - st4_ff : st4_ff;
      m5_in = (2*ST_W)'(st4_ff) * (2*ST_W)'(mul_b);
   end

   // ---------------------------------------------------------------------
   // Stage 6: rounding of the product, final select and saturation.
   // ---------------------------------------------------------------------
   logic [2*ST_W-1:0]        m_sum;
   logic [ST_W-1:0]          m_rnd;
   logic signed [RES_W-1:0]  st_r;
   logic signed [RES_W-1:0]  tab_r;
   logic signed [RES_W-1:0]  res_r;
   logic [DATA_WIDTH-1:0]    out_in, out_ff;

   always_comb begin
      m_sum = m5_ff + ((2*ST_W)'(1) << (FRAC_BITS - 1));
      m_rnd = m_sum[FRAC_BITS +: ST_W];
      st_r  = signed'(RES_W'(st5_ff));
      if (cfg.kind == KIND_TANH) begin
         if (ctl5_ff.deriv) tab_r = signed'(RES_W'(ONE_FRAC - m_rnd));
         else tab_r = ctl5_ff.neg ? -st_r : st_r;
      end else begin
         tab_r = ctl5_ff.deriv ? signed'(RES_W'(m_rnd)) : st_r;
      end
      unique case (cfg.kind) inside
         KIND_SIGMOID,
         KIND_TANH: res_r = tab_r;
         default:   res_r = dir5_ff;
      endcase
      out_in = saturate(res_r);
   end

   // Payload registers; only the valid bits above are reset.
   always_ff @(posedge clock) begin
      lp1_ff  <= lp1_in;
      x1_ff   <= req_value_in;
      ctl1_ff <= ctl1_in;
      ctl2_ff <= ctl1_ff;
      ctl3_ff <= ctl2_ff;
      ctl4_ff <= ctl3_ff;
      ctl5_ff <= ctl4_ff;
      dir2_ff <= dir2_in;
      dir3_ff <= dir2_ff;
      dir4_ff <= dir3_ff;
      dir5_ff <= dir4_ff;
      st4_ff  <= st4_in;
      st5_ff  <= st4_ff;
      m5_ff   <= m5_in;
      out_ff  <= out_in;
   end

   assign rsp_strobe    = vld_ff[LATENCY-1];
   assign rsp_value_out = signed'(out_ff);

   // ---------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------

   // Every accepted request yields exactly one result, a fixed latency later.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(accept, LATENCY))
      else $error("result strobe does not follow the accepted request");

   // The cycle after a reset edge carries no result.
   assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // Sigmoid, relu and their derivatives are never negative.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (cfg.kind == KIND_SIGMOID || cfg.kind == KIND_RELU))
      |-> !rsp_value_out[DATA_WIDTH-1])
      else $error("negative sigmoid or relu result");

endmodule

`default_nettype wire

// ===== rtl/core/nau_csr.sv =====
`default_nettype none

module nau_csr import nau_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output cfg_type            cfg
);

   cfg_type               cfg_ff;
   logic [CSR_IDX_W-1:0]  idx;
   logic                  wr_en;

   assign idx    = paddr[PADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kind  <= KIND_RELU;
         cfg_ff.slope <= SLOPE_RESET;
      end else if (wr_en) begin
         unique case (idx)
            CSR_KIND:  cfg_ff.kind  <= pwdata[KIND_W-1:0];
            CSR_SLOPE: cfg_ff.slope <= pwdata[SLOPE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_KIND:  prdata = 32'(cfg_ff.kind);
         CSR_SLOPE: prdata = 32'(cfg_ff.slope);
         default:   prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/nau_interp.sv =====
`default_nettype none

// Three-stage piecewise-linear sigmoid lookup: table read, slope multiply,
// rounded add. The result is in Q2.30.
module nau_interp import nau_pkg::*; (
   input  logic             clock,
   input  logic [MAG_W-1:0] mag_in,
   output logic [ROM_W-1:0] p_out
);

   localparam int PROD_W = ROM_W + SEG_SHIFT;

   logic [NUM_W-1:0]      num;
   logic [NUM_W-SEG_SHIFT-1:0] seg;
   logic                  at_end;
   logic [IDX_W-1:0]      idx;
   logic [ROM_W-1:0]      lo;
   logic [ROM_W-1:0]      hi;

   logic [ROM_W-1:0]      lo1_ff, lo1_in;
   logic [ROM_W-1:0]      diff1_ff, diff1_in;
   logic [SEG_SHIFT-1:0]  rem1_ff, rem1_in;
   logic [ROM_W-1:0]      lo2_ff;
   logic [PROD_W-1:0]     prod2_ff, prod2_in;
   logic [ROM_W-1:0]      p3_ff, p3_in;
   logic [PROD_W:0]       acc;

   // Stage 1: segment and offset. The span is a power of two, so the
   // position splits by a shift.
   always_comb begin
      num    = NUM_W'(mag_in) * NUM_W'(TABLE_SEGMENTS);
      seg    = num[NUM_W-1:SEG_SHIFT];
      at_end = 32'(seg) >= 32'(TABLE_SEGMENTS);
      idx    = at_end ? IDX_W'(0) : IDX_W'(seg);
      lo     = SIG_ROM[idx];
      hi     = SIG_ROM[idx + IDX_W'(1)];
      if (at_end) begin
         lo1_in   = SIG_ROM[TABLE_SEGMENTS];
         diff1_in = '0;
         rem1_in  = '0;
      end else begin
         lo1_in   = lo;
         diff1_in = (hi >= lo) ? hi - lo : '0;
         rem1_in  = num[SEG_SHIFT-1:0];
      end
   end

   // Stage 2: slope times offset.
   assign prod2_in = PROD_W'(diff1_ff) * PROD_W'(rem1_ff);

   // Stage 3: base plus rounded fraction in one add.
   always_comb begin
      acc   = {1'b0, lo2_ff, {SEG_SHIFT{1'b0}}} + (PROD_W + 1)'(prod2_ff)
            + ((PROD_W + 1)'(1) << (SEG_SHIFT - 1));
      p3_in = acc[SEG_SHIFT +: ROM_W];
   end

   always_ff @(posedge clock) begin
      lo1_ff   <= lo1_in;
      diff1_ff <= diff1_in;
      rem1_ff  <= rem1_in;
      lo2_ff   <= lo1_ff;
      prod2_ff <= prod2_in;
      p3_ff    <= p3_in;
   end

   assign p_out = p3_ff;

endmodule

`default_nettype wire
